// ===== rtl/sqpq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sorted search priority queue.
// Holds the entry layout, action codes and cell control word; no dependencies.
package sqpq_pkg;

    localparam int CAPACITY      = 256;
    localparam int ROW_W         = 10;
    localparam int COL_W         = 10;
    localparam int COST_W        = 16;
    localparam int KEY_W         = COST_W + 1;
    localparam int PREFIX_LEVELS = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_POP    = 2'd1,
        ACT_INSERT = 2'd2,
        ACT_REPOS  = 2'd3
    } t_action;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              side;
        logic [COST_W-1:0] path;
        logic [COST_W-1:0] est;
    } t_entry;

    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_CLEAR  = 3'd1,
        CELL_POP    = 3'd2,
        CELL_INSERT = 3'd3,
        CELL_REMOVE = 3'd4
    } t_cell_op;

    // Broadcast to every cell of the row
    typedef struct packed {
        t_cell_op         op;
        t_entry           entry;
        logic [KEY_W-1:0] key;
        logic [ROW_W-1:0] goal_row;
        logic [COL_W-1:0] goal_col;
    } t_cell_ctl;

    function automatic logic [KEY_W-1:0] key_of(input t_entry e);
        return {1'b0, e.path} + {1'b0, e.est};
    endfunction

endpackage

// ===== rtl/sqpq_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and result words.
// Depends on sqpq_pkg for field widths.
interface sqpq_in_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       action;
    logic [sqpq_pkg::ROW_W-1:0]       cell_row;
    logic [sqpq_pkg::COL_W-1:0]       cell_col;
    logic                             cell_side;
    logic [sqpq_pkg::COST_W-1:0]      path_cost;
    logic [sqpq_pkg::COST_W-1:0]      estimate_cost;
    logic [sqpq_pkg::ROW_W-1:0]       goal_row;
    logic [sqpq_pkg::COL_W-1:0]       goal_col;

    modport source (output valid, action, cell_row, cell_col, cell_side, path_cost,
                    estimate_cost, goal_row, goal_col, input ready);
    modport sink   (input valid, action, cell_row, cell_col, cell_side, path_cost,
                    estimate_cost, goal_row, goal_col, output ready);
endinterface

interface sqpq_out_if;
    logic                             valid;
    logic                             ready;
    logic [sqpq_pkg::ROW_W-1:0]       out_row;
    logic [sqpq_pkg::COL_W-1:0]       out_col;
    logic                             out_side;
    logic [sqpq_pkg::COST_W-1:0]      out_path_cost;
    logic [sqpq_pkg::COST_W-1:0]      out_estimate_cost;
    logic                             was_empty;
    logic                             accepted;

    modport source (output valid, out_row, out_col, out_side, out_path_cost,
                    out_estimate_cost, was_empty, accepted, input ready);
    modport sink   (input valid, out_row, out_col, out_side, out_path_cost,
                    out_estimate_cost, was_empty, accepted, output ready);
endinterface

// ===== rtl/sqpq_cell.sv =====
`timescale 1ns / 1ps
// One slot of the sorted row: holds an entry and its occupied flag.
// Depends on sqpq_pkg; trades entries with its two neighbors.
module sqpq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sqpq_pkg::t_cell_ctl i_ctl,
    input  logic                i_is_head,
    input  logic                i_prev_valid,
    input  logic                i_prev_stay,
    input  logic                i_prev_gt,
    input  sqpq_pkg::t_entry    i_prev_entry,
    input  logic                i_next_valid,
    input  sqpq_pkg::t_entry    i_next_entry,
    input  logic                i_rm_before,
    output sqpq_pkg::t_entry    o_entry,
    output logic                o_valid,
    output logic                o_stay,
    output logic                o_gt,
    output logic                o_match
);

    sqpq_pkg::t_entry             r_entry, n_entry;
    logic                         r_valid, n_valid;
    logic [sqpq_pkg::KEY_W-1:0]   w_key;
    logic                         w_gt;
    logic                         w_tie;

    // Compare own key against the new one; a goal tie only holds the first
    // slot whose key is not below the new key
    assign w_key   = sqpq_pkg::key_of(r_entry);
    assign w_gt    = r_valid && (i_is_head ? (w_key <= i_ctl.key) : (i_ctl.key > w_key));
    assign w_tie   = r_valid && (w_key == i_ctl.key) && (r_entry.row == i_ctl.goal_row)
                     && (r_entry.col == i_ctl.goal_col);
    assign o_stay  = w_gt || (!i_is_head && w_tie && i_prev_gt);
    assign o_gt    = w_gt;
    assign o_match = r_valid && (r_entry.row == i_ctl.entry.row)
                     && (r_entry.col == i_ctl.entry.col) && (r_entry.side == i_ctl.entry.side);

    // Pick next contents per operation
    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        case (i_ctl.op)
            sqpq_pkg::CELL_CLEAR: begin
                n_valid = 1'b0;
            end
            sqpq_pkg::CELL_POP: begin
                n_entry = i_next_entry;
                n_valid = i_next_valid;
            end
            sqpq_pkg::CELL_INSERT: begin
                if (!o_stay) begin
                    n_entry = (i_is_head || i_prev_stay) ? i_ctl.entry : i_prev_entry;
                end
                n_valid = r_valid | i_prev_valid | i_is_head;
            end
            sqpq_pkg::CELL_REMOVE: begin
                if (i_rm_before || o_match) begin
                    n_entry = i_next_entry;
                    n_valid = i_next_valid;
                end
            end
            default: begin
                n_entry = r_entry;
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

// ===== rtl/sorted_search_priority_queue.sv =====
`timescale 1ns / 1ps
// Top level of the sorted open-list priority queue: a row of sqpq_cell slots.
// Depends on sqpq_pkg, sqpq_if and sqpq_cell.
//
// Usage: requests arrive as words on i_in (valid/ready); each request gives
// exactly one result word on o_out (valid/ready). Actions: clear, pop the
// smallest entry, insert, and reposition (drop the first entry of the same
// cell, then insert). Entries stay sorted by path plus estimate cost.
// Timing: clear, pop and insert complete at the accepting edge, which also
// registers the result word. Reposition does the removal shift across the
// row at the accepting edge, then the insertion shift in the S_INS state.
// Throughput: one request per cycle while o_out drains, none while in S_INS;
// a request is taken only when the result register is empty or being read,
// so a stalled receiver holds i_in.ready low and the queue contents intact.
// The cost per request is set by the compare-and-shift done by all slots in
// parallel plus the log-depth first-match scan for reposition.
// Reset (i_rst_n low, synchronous) empties the queue and the result register;
// no clearing pass is needed since each slot has its own occupied flag.
module sorted_search_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sqpq_in_if.sink     i_in,
    sqpq_out_if.source  o_out
);

    localparam int N = sqpq_pkg::CAPACITY;
    localparam int L = sqpq_pkg::PREFIX_LEVELS;

    typedef enum logic {S_IDLE, S_INS} t_state;

    t_state                r_state;
    sqpq_pkg::t_entry      r_req;
    logic [sqpq_pkg::ROW_W-1:0] r_goal_row;
    logic [sqpq_pkg::COL_W-1:0] r_goal_col;
    logic                  r_out_valid;
    sqpq_pkg::t_entry      r_out_entry;
    logic                  r_was_empty;
    logic                  r_accepted;

    sqpq_pkg::t_entry      w_entry [N];
    logic [N-1:0]          w_valid;
    logic [N-1:0]          w_stay;
    logic [N-1:0]          w_gt;
    logic [N-1:0]          w_match;
    logic [N-1:0]          w_pre [L+1];
    logic [N-1:0]          w_before;
    sqpq_pkg::t_cell_ctl   w_ctl;
    sqpq_pkg::t_entry      w_in_entry;
    logic                  w_fire;
    logic                  w_full;
    logic                  w_empty;

    assign w_full  = w_valid[N-1];
    assign w_empty = !w_valid[0];

    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign w_fire     = i_in.valid && i_in.ready;

    assign w_in_entry.row  = i_in.cell_row;
    assign w_in_entry.col  = i_in.cell_col;
    assign w_in_entry.side = i_in.cell_side;
    assign w_in_entry.path = i_in.path_cost;
    assign w_in_entry.est  = i_in.estimate_cost;

    // Build the broadcast control word
    always_comb begin
        w_ctl.entry    = (r_state == S_INS) ? r_req : w_in_entry;
        w_ctl.goal_row = (r_state == S_INS) ? r_goal_row : i_in.goal_row;
        w_ctl.goal_col = (r_state == S_INS) ? r_goal_col : i_in.goal_col;
        w_ctl.key      = sqpq_pkg::key_of(w_ctl.entry);
        w_ctl.op       = sqpq_pkg::CELL_HOLD;
        if (r_state == S_INS) begin
            w_ctl.op = w_full ? sqpq_pkg::CELL_HOLD : sqpq_pkg::CELL_INSERT;
        end else if (w_fire) begin
            case (sqpq_pkg::t_action'(i_in.action))
                sqpq_pkg::ACT_CLEAR:  w_ctl.op = sqpq_pkg::CELL_CLEAR;
                sqpq_pkg::ACT_POP:    w_ctl.op = sqpq_pkg::CELL_POP;
                sqpq_pkg::ACT_INSERT: w_ctl.op = w_full ? sqpq_pkg::CELL_HOLD
                                                        : sqpq_pkg::CELL_INSERT;
                sqpq_pkg::ACT_REPOS:  w_ctl.op = sqpq_pkg::CELL_REMOVE;
                default:              w_ctl.op = sqpq_pkg::CELL_HOLD;
            endcase
        end
    end

    // Flag slots past the first matching cell (log-depth prefix OR)
    assign w_pre[0] = w_match;
    for (genvar l = 0; l < L; l++) begin : g_pre
        assign w_pre[l+1] = w_pre[l] | (w_pre[l] << (1 << l));
    end
    assign w_before = w_pre[L] << 1;

    // Row of slots, head first
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic             w_pv, w_ps, w_pg, w_nv;
        sqpq_pkg::t_entry w_pe, w_ne;
        if (g == 0) begin : g_head
            assign w_pv = 1'b0;
            assign w_ps = 1'b0;
            assign w_pg = 1'b0;
            assign w_pe = '0;
        end else begin : g_body
            assign w_pv = w_valid[g-1];
            assign w_ps = w_stay[g-1];
            assign w_pg = w_gt[g-1];
            assign w_pe = w_entry[g-1];
        end
        if (g == N-1) begin : g_tail
            assign w_nv = 1'b0;
            assign w_ne = '0;
        end else begin : g_inner
            assign w_nv = w_valid[g+1];
            assign w_ne = w_entry[g+1];
        end
        sqpq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_is_head    (g == 0),
            .i_prev_valid (w_pv),
            .i_prev_stay  (w_ps),
            .i_prev_gt    (w_pg),
            .i_prev_entry (w_pe),
            .i_next_valid (w_nv),
            .i_next_entry (w_ne),
            .i_rm_before  (w_before[g]),
            .o_entry      (w_entry[g]),
            .o_valid      (w_valid[g]),
            .o_stay       (w_stay[g]),
            .o_gt         (w_gt[g]),
            .o_match      (w_match[g])
        );
    end

    // Sequence requests and hold the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_INS) begin
                r_state     <= S_IDLE;
                r_out_valid <= 1'b1;
                r_out_entry <= '0;
                r_was_empty <= 1'b0;
                r_accepted  <= !w_full;
            end else if (w_fire) begin
                r_out_entry <= '0;
                r_was_empty <= 1'b0;
                r_accepted  <= 1'b0;
                case (sqpq_pkg::t_action'(i_in.action))
                    sqpq_pkg::ACT_POP: begin
                        r_out_valid <= 1'b1;
                        r_was_empty <= w_empty;
                        if (!w_empty) begin
                            r_out_entry <= w_entry[0];
                        end
                    end
                    sqpq_pkg::ACT_INSERT: begin
                        r_out_valid <= 1'b1;
                        r_accepted  <= !w_full;
                    end
                    sqpq_pkg::ACT_REPOS: begin
                        r_state    <= S_INS;
                        r_req      <= w_in_entry;
                        r_goal_row <= i_in.goal_row;
                        r_goal_col <= i_in.goal_col;
                    end
                    default: begin
                        r_out_valid <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.out_row           = r_out_entry.row;
    assign o_out.out_col           = r_out_entry.col;
    assign o_out.out_side          = r_out_entry.side;
    assign o_out.out_path_cost     = r_out_entry.path;
    assign o_out.out_estimate_cost = r_out_entry.est;
    assign o_out.was_empty         = r_was_empty;
    assign o_out.accepted          = r_accepted;

endmodule

// ===== rtl/sqpq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the priority queue, bound to the top level.
// Depends on sqpq_pkg for field widths.
module sqpq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [sqpq_pkg::ROW_W-1:0]    i_out_row,
    input logic [sqpq_pkg::COL_W-1:0]    i_out_col,
    input logic                          i_out_side,
    input logic [sqpq_pkg::COST_W-1:0]   i_out_path_cost,
    input logic [sqpq_pkg::COST_W-1:0]   i_out_estimate_cost,
    input logic                          i_was_empty,
    input logic                          i_accepted
);

    // Reset drops any pending result word
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result word valid after reset");

    // Hold a stalled result word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_row)
        && $stable(i_out_col) && $stable(i_out_path_cost) && $stable(i_accepted))
        else $error("stalled result word changed");

    // Empty flag and store flag never together
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_was_empty && i_accepted))
        else $error("was_empty and accepted both set");

    // Results flagged empty or accepted carry zero cell fields
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_was_empty || i_accepted) |-> i_out_row == '0
        && i_out_col == '0 && !i_out_side && i_out_path_cost == '0
        && i_out_estimate_cost == '0)
        else $error("cell fields not zero");

endmodule

bind sorted_search_priority_queue sqpq_checker u_sqpq_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_row           (o_out.out_row),
    .i_out_col           (o_out.out_col),
    .i_out_side          (o_out.out_side),
    .i_out_path_cost     (o_out.out_path_cost),
    .i_out_estimate_cost (o_out.out_estimate_cost),
    .i_was_empty         (o_out.was_empty),
    .i_accepted          (o_out.accepted)
);

// ===== test/sorted_search_priority_queue_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the sorted open-list priority queue.
// Depends on sqpq_pkg, sqpq_if and sorted_search_priority_queue.
module sorted_search_priority_queue_test;
    import sqpq_pkg::*;

    typedef struct packed {
        t_action          action;
        t_entry           item;
        logic [ROW_W-1:0] goal_row;
        logic [COL_W-1:0] goal_col;
    } t_request;

    typedef struct packed {
        t_entry item;
        logic   was_empty;
        logic   accepted;
    } t_reply;

    logic i_clk;
    logic i_rst_n;

    sqpq_in_if  req_ch ();
    sqpq_out_if rsp_ch ();

    sorted_search_priority_queue dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch),
        .o_out  (rsp_ch)
    );

    // Shadow copy of the open list
    t_entry   open_list[$];
    t_request pending_words[$];
    t_reply   expected_replies[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;
    int  mismatch_count;
    bit  drain_pause;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [KEY_W-1:0] cost_sum(input t_entry e);
        return {1'b0, e.path} + {1'b0, e.est};
    endfunction

    // Insert into the shadow list following the head and goal tie rules
    function automatic logic place_entry(input t_entry e, input logic [ROW_W-1:0] gr,
                                         input logic [COL_W-1:0] gc);
        logic [KEY_W-1:0] k;
        int               pos;
        k = cost_sum(e);
        if (open_list.size() >= CAPACITY) return 1'b0;
        if (open_list.size() == 0 || cost_sum(open_list[0]) > k) begin
            pos = 0;
        end else begin
            pos = 1;
            while (pos < open_list.size() && k > cost_sum(open_list[pos])) pos++;
            if (pos < open_list.size() && cost_sum(open_list[pos]) == k &&
                open_list[pos].row == gr && open_list[pos].col == gc)
                pos++;
        end
        open_list.insert(pos, e);
        return 1'b1;
    endfunction

    function automatic t_reply predict_reply(input t_request r);
        t_reply rep;
        rep = '0;
        case (r.action)
            ACT_CLEAR: open_list.delete();
            ACT_POP: begin
                if (open_list.size() == 0) begin
                    rep.was_empty = 1'b1;
                end else begin
                    rep.item = open_list.pop_front();
                end
            end
            ACT_INSERT: rep.accepted = place_entry(r.item, r.goal_row, r.goal_col);
            default: begin
                foreach (open_list[i]) begin
                    if (open_list[i].row == r.item.row && open_list[i].col == r.item.col &&
                        open_list[i].side == r.item.side) begin
                        open_list.delete(i);
                        break;
                    end
                end
                rep.accepted = place_entry(r.item, r.goal_row, r.goal_col);
            end
        endcase
        return rep;
    endfunction

    // Driver: offer the next pending word, hold it while stalled, advance on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_replies.push_back(predict_reply(pending_words.pop_front()));
            end
            if (pending_words.size() > 0 &&
                ((req_ch.valid && !req_ch.ready) ||
                 (!drain_pause && ($urandom_range(99) >= send_idle_pct)))) begin
                req_ch.valid         <= 1'b1;
                req_ch.action        <= pending_words[0].action;
                req_ch.cell_row      <= pending_words[0].item.row;
                req_ch.cell_col      <= pending_words[0].item.col;
                req_ch.cell_side     <= pending_words[0].item.side;
                req_ch.path_cost     <= pending_words[0].item.path;
                req_ch.estimate_cost <= pending_words[0].item.est;
                req_ch.goal_row      <= pending_words[0].goal_row;
                req_ch.goal_col      <= pending_words[0].goal_col;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.out_row, rsp_ch.out_col, rsp_ch.out_side, rsp_ch.out_path_cost,
                   rsp_ch.out_estimate_cost, rsp_ch.was_empty, rsp_ch.accepted};
            if (expected_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result word %h", got);
            end else begin
                want = expected_replies.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Receiver stall, with a long hold-off counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ch.ready    <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_request make_word(input t_action a, input int r, input int c,
                                           input int s, input int p, input int e,
                                           input int gr, input int gc);
        t_request w;
        w.action        = a;
        w.item.row      = ROW_W'(r);
        w.item.col      = COL_W'(c);
        w.item.side     = 1'(s);
        w.item.path     = COST_W'(p);
        w.item.est      = COST_W'(e);
        w.goal_row      = ROW_W'(gr);
        w.goal_col      = COL_W'(gc);
        return w;
    endfunction

    // Searches mostly over a small grid so repositions and goal ties hit
    function automatic t_request random_word();
        int  pick;
        int  span;
        t_action a;
        pick = $urandom_range(99);
        span = ($urandom_range(9) == 0) ? 1023 : 7;
        if (pick < 3)       a = ACT_CLEAR;
        else if (pick < 38) a = ACT_POP;
        else if (pick < 75) a = ACT_INSERT;
        else                a = ACT_REPOS;
        if ($urandom_range(4) == 0)
            return make_word(a, $urandom_range(span), $urandom_range(span), $urandom_range(1),
                             $urandom_range(65535), $urandom_range(65535),
                             $urandom_range(span), $urandom_range(span));
        return make_word(a, $urandom_range(span), $urandom_range(span), $urandom_range(1),
                         $urandom_range(20), $urandom_range(20),
                         $urandom_range(span), $urandom_range(span));
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || req_ch.valid || expected_replies.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int count, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (count) pending_words.push_back(random_word());
        wait_drained();
    endtask

    initial begin
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        mismatch_count  = 0;
        drain_pause     = 1'b0;
        i_rst_n         = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.action        = ACT_CLEAR;
        req_ch.cell_row      = '0;
        req_ch.cell_col      = '0;
        req_ch.cell_side     = 1'b0;
        req_ch.path_cost     = '0;
        req_ch.estimate_cost = '0;
        req_ch.goal_row      = '0;
        req_ch.goal_col      = '0;
        rsp_ch.ready         = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pop, extremes, head rule, goal tie, reposition, clear
        pending_words.push_back(make_word(ACT_POP, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(ACT_INSERT, 1023, 1023, 1, 65535, 65535, 0, 0));
        pending_words.push_back(make_word(ACT_INSERT, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(ACT_INSERT, 5, 5, 0, 10, 10, 0, 0));
        pending_words.push_back(make_word(ACT_INSERT, 6, 6, 1, 20, 0, 5, 5));
        pending_words.push_back(make_word(ACT_INSERT, 7, 7, 0, 0, 20, 0, 0));
        pending_words.push_back(make_word(ACT_INSERT, 8, 8, 1, 0, 0, 0, 0));
        pending_words.push_back(make_word(ACT_INSERT, 9, 9, 0, 0, 0, 8, 8));
        pending_words.push_back(make_word(ACT_REPOS, 5, 5, 0, 1, 1, 0, 0));
        pending_words.push_back(make_word(ACT_REPOS, 5, 5, 1, 3, 3, 0, 0));
        pending_words.push_back(make_word(ACT_REPOS, 1023, 1023, 1, 2, 2, 0, 0));
        repeat (6) pending_words.push_back(make_word(ACT_POP, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(ACT_INSERT, 682, 341, 1, 43690, 21845, 0, 0));
        pending_words.push_back(make_word(ACT_INSERT, 341, 682, 0, 21845, 43690, 0, 0));
        pending_words.push_back(make_word(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(ACT_POP, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        // Fill past capacity while the receiver holds off, then refuse when full
        hold_off_cycles = 400;
        for (int i = 0; i < CAPACITY + 4; i++)
            pending_words.push_back(make_word(ACT_INSERT, i % 1024, i % 7, i % 2,
                                              $urandom_range(30), $urandom_range(30),
                                              $urandom_range(7), $urandom_range(7)));
        pending_words.push_back(make_word(ACT_REPOS, 1023, 1023, 1, 0, 0, 0, 0));
        pending_words.push_back(make_word(ACT_REPOS, 3, 3, 1, 0, 0, 0, 0));
        wait_drained();
        pending_words.push_back(make_word(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        run_phase(80, 0, 0);
        run_phase(70, 75, 0);
        drain_pause = 1'b1;
        pending_words.push_back(random_word());
        repeat (20) @(posedge i_clk);
        drain_pause = 1'b0;
        run_phase(70, 0, 75);
        run_phase(70, 33, 33);
        run_phase(75, 0, 0);

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_replies.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== sorted_search_priority_queue.f =====
rtl/sqpq_pkg.sv
rtl/sqpq_if.sv
rtl/sqpq_cell.sv
rtl/sorted_search_priority_queue.sv
rtl/sqpq_checker.sv
test/sorted_search_priority_queue_test.sv
